// ===== rtl/pwmc_pkg.sv =====
// Shared types and constants for the power window motor controller.
`default_nettype none

package pwmc_pkg;

  localparam int CFG_W          = 16;
  localparam int TIMER_BITS_DEF = 16;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  localparam logic [CFG_W-1:0] HOLD_TICKS_RST      = 16'd2000;
  localparam logic [CFG_W-1:0] INDICATOR_TICKS_RST = 16'd250;

  localparam logic REG_HOLD_TICKS      = 1'b0;
  localparam logic REG_INDICATOR_TICKS = 1'b1;

  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_QUAL     = 3'd1;
  localparam logic [2:0] MODE_MANUAL   = 3'd2;
  localparam logic [2:0] MODE_ONETOUCH = 3'd3;
  localparam logic [2:0] MODE_HOLD     = 3'd4;

  typedef struct packed {
    logic passenger_open_btn;
    logic passenger_close_btn;
    logic driver_open_btn;
    logic driver_close_btn;
    logic open_limit;
    logic close_limit;
    logic jam_detect;
    logic passenger_unlock;
    logic passenger_lock;
  } item_t;

  typedef struct packed {
    logic       motor_open;
    logic       motor_close;
    logic       limit_indicator;
    logic       passenger_enabled;
    logic [2:0] mode;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/pwmc_core.sv =====
// Window control state and the per-tick next-state logic.
`default_nettype none

module pwmc_core #(
  parameter int TIMER_BITS = pwmc_pkg::TIMER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  pwmc_pkg::item_t                item,
  input  logic [pwmc_pkg::CFG_W-1:0]     hold_ticks,
  input  logic [pwmc_pkg::CFG_W-1:0]     indicator_ticks,
  output pwmc_pkg::result_t              result
);
  import pwmc_pkg::*;

  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  logic [2:0]            mode_r, mode_nxt;
  logic                  dir_r, dir_nxt;
  logic                  owner_r, owner_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic                  pen_r, pen_nxt;
  logic                  jam_r, jam_nxt;
  logic [3:0]            prev_r;

  logic [3:0]            lv;
  logic [3:0]            edges;
  logic [TIMER_BITS-1:0] timer_inc;
  logic                  hold_done;
  logic                  ind_done;
  logic                  held;
  logic                  lim;
  logic                  drv_pick;
  logic [1:0]            drv_idx;
  logic                  any_pick;
  logic [1:0]            any_idx;
  logic                  start;
  logic [1:0]            start_idx;
  logic                  run;
  logic                  running;

  always_comb begin
    lv        = {item.driver_close_btn, item.driver_open_btn,
                 item.passenger_close_btn, item.passenger_open_btn};
    edges     = lv & ~prev_r;
    timer_inc = (&timer_r) ? timer_r : TIMER_BITS'(timer_r + 1'b1);
    hold_done = CMP_W'(timer_inc) >= CMP_W'(hold_ticks);
    ind_done  = CMP_W'(timer_inc) >= CMP_W'(indicator_ticks);
    held      = lv[{owner_r, dir_r}];
    lim       = dir_r ? item.close_limit : item.open_limit;
    drv_pick  = edges[2] | edges[3];
    drv_idx   = edges[2] ? 2'd2 : 2'd3;

    mode_nxt  = mode_r;
    dir_nxt   = dir_r;
    owner_nxt = owner_r;
    timer_nxt = timer_r;
    pen_nxt   = pen_r;
    jam_nxt   = jam_r;
    start     = 1'b0;
    start_idx = drv_idx;
    run       = 1'b0;

    // lock wins over unlock and drops passenger-owned motion at once
    if (item.passenger_lock) begin
      pen_nxt = 1'b0;
      if (!owner_r && (mode_r == MODE_QUAL || mode_r == MODE_MANUAL ||
                       mode_r == MODE_ONETOUCH)) begin
        mode_nxt = MODE_IDLE;
      end
    end else if (item.passenger_unlock) begin
      pen_nxt = 1'b1;
    end
    if (item.jam_detect) begin
      jam_nxt = 1'b1;
    end

    any_pick = drv_pick || (pen_nxt && (edges[0] | edges[1]));
    any_idx  = drv_pick ? drv_idx : (edges[0] ? 2'd0 : 2'd1);

    unique case (mode_nxt)
      MODE_IDLE: begin
        if (any_pick) begin
          start     = 1'b1;
          start_idx = any_idx;
        end
      end
      MODE_ONETOUCH: begin
        if (any_pick) begin
          start     = 1'b1;
          start_idx = any_idx;
        end else begin
          run = 1'b1;
        end
      end
      MODE_QUAL: begin
        if (!owner_r && drv_pick) begin
          start = 1'b1;
        end else begin
          timer_nxt = timer_inc;
          if (hold_done) begin
            if (lim) begin
              mode_nxt = MODE_IDLE;
            end else begin
              mode_nxt = held ? MODE_MANUAL : MODE_ONETOUCH;
              run      = 1'b1;
            end
          end
        end
      end
      MODE_MANUAL: begin
        if (!owner_r && drv_pick) begin
          start = 1'b1;
        end else begin
          run = 1'b1;
        end
      end
      MODE_HOLD: begin
        timer_nxt = timer_inc;
        if (ind_done) begin
          mode_nxt = MODE_IDLE;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase

    if (start) begin
      owner_nxt = start_idx[1];
      dir_nxt   = start_idx[0];
      mode_nxt  = MODE_QUAL;
      timer_nxt = '0;
    end

    if (run) begin
      priority if (!owner_r && !pen_nxt) begin
        mode_nxt = MODE_IDLE;
      end else if (mode_nxt == MODE_MANUAL && !held) begin
        mode_nxt = MODE_IDLE;
      end else if (lim) begin
        mode_nxt  = MODE_HOLD;
        timer_nxt = '0;
      end else if (mode_nxt == MODE_ONETOUCH && dir_r && jam_nxt) begin
        jam_nxt  = 1'b0;
        mode_nxt = MODE_IDLE;
      end else if (owner_r) begin
        pen_nxt = 1'b0;
      end
    end

    running                  = (mode_nxt == MODE_MANUAL) || (mode_nxt == MODE_ONETOUCH);
    result.motor_open        = running && !dir_nxt;
    result.motor_close       = running && dir_nxt;
    result.limit_indicator   = mode_nxt == MODE_HOLD;
    result.passenger_enabled = pen_nxt;
    result.mode              = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      dir_r   <= 1'b0;
      owner_r <= 1'b0;
      timer_r <= '0;
      pen_r   <= 1'b0;
      jam_r   <= 1'b0;
      prev_r  <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      dir_r   <= dir_nxt;
      owner_r <= owner_nxt;
      timer_r <= timer_nxt;
      pen_r   <= pen_nxt;
      jam_r   <= jam_nxt;
      prev_r  <= lv;
    end
  end

  a_lock_disables: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.passenger_lock |=> !pen_r)
    else $error("lock did not disable passenger buttons");

  a_driver_run_locks_out: assert property (@(posedge clk) disable iff (!rst_n)
    step && (result.motor_open || result.motor_close) && owner_nxt
      |-> !result.passenger_enabled)
    else $error("passenger enabled during driver motion");

  a_hold_exit: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_HOLD |=> mode_r == MODE_HOLD || mode_r == MODE_IDLE)
    else $error("limit hold left to a mode other than idle");

  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    step && mode_r == MODE_IDLE |=> mode_r != MODE_MANUAL && mode_r != MODE_ONETOUCH)
    else $error("motion started without qualifying");

endmodule

`default_nettype wire

// ===== rtl/power_window_motor_controller.sv =====
// Power window motor controller top level: register port, input and result registers.
//
// Usage: one input beat per tick carries the button levels, limit switches, jam pulse
// and passenger lock/unlock pulses. Each input beat yields exactly one result beat with
// the motor drive, limit indicator, passenger enable and mode after that tick.
// Both channels are valid/ready. An accepted beat waits in the input register, is evaluated
// by the combinational state logic and lands in the result register: out_valid rises as the
// beat is written there, and a new beat is taken every cycle while out_ready stays high.
// When the receiver holds out_ready low the result register keeps its beat; the input
// register may still fill, then in_ready drops until the result moves on.
// The APB port holds hold_ticks at byte address 0 and indicator_ticks at 4; write them
// only while no beat is in flight. pready is tied high, no wait states.
// Reset (rst_n low, synchronous) empties both registers, sets the mode to idle, the
// passenger buttons to disabled, and the timing registers to 2000 and 250 ticks.
`default_nettype none

module power_window_motor_controller #(
  parameter int TIMER_BITS = pwmc_pkg::TIMER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_passenger_open_btn,
  input  logic                           in_passenger_close_btn,
  input  logic                           in_driver_open_btn,
  input  logic                           in_driver_close_btn,
  input  logic                           in_open_limit,
  input  logic                           in_close_limit,
  input  logic                           in_jam_detect,
  input  logic                           in_passenger_unlock,
  input  logic                           in_passenger_lock,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_motor_open,
  output logic                           out_motor_close,
  output logic                           out_limit_indicator,
  output logic                           out_passenger_enabled,
  output logic [2:0]                     out_mode,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pwmc_pkg::PADDR_W-1:0]   paddr,
  input  logic [pwmc_pkg::PDATA_W-1:0]   pwdata,
  output logic [pwmc_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import pwmc_pkg::*;

  logic [CFG_W-1:0] hold_ticks_r;
  logic [CFG_W-1:0] indicator_ticks_r;
  logic             s1_valid_r;
  item_t            s1_item_r;
  logic             out_valid_r;
  result_t          out_res_r;
  result_t          step_res;
  logic             advance;
  logic             cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    unique case (paddr[2])
      REG_HOLD_TICKS:      prdata = {{(PDATA_W-CFG_W){1'b0}}, hold_ticks_r};
      REG_INDICATOR_TICKS: prdata = {{(PDATA_W-CFG_W){1'b0}}, indicator_ticks_r};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r      <= HOLD_TICKS_RST;
      indicator_ticks_r <= INDICATOR_TICKS_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_HOLD_TICKS) begin
        hold_ticks_r <= pwdata[CFG_W-1:0];
      end else begin
        indicator_ticks_r <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.passenger_open_btn  <= in_passenger_open_btn;
      s1_item_r.passenger_close_btn <= in_passenger_close_btn;
      s1_item_r.driver_open_btn     <= in_driver_open_btn;
      s1_item_r.driver_close_btn    <= in_driver_close_btn;
      s1_item_r.open_limit          <= in_open_limit;
      s1_item_r.close_limit         <= in_close_limit;
      s1_item_r.jam_detect          <= in_jam_detect;
      s1_item_r.passenger_unlock    <= in_passenger_unlock;
      s1_item_r.passenger_lock      <= in_passenger_lock;
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  pwmc_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .item           (s1_item_r),
    .hold_ticks     (hold_ticks_r),
    .indicator_ticks(indicator_ticks_r),
    .result         (step_res)
  );

  assign out_valid             = out_valid_r;
  assign out_motor_open        = out_res_r.motor_open;
  assign out_motor_close       = out_res_r.motor_close;
  assign out_limit_indicator   = out_res_r.limit_indicator;
  assign out_passenger_enabled = out_res_r.passenger_enabled;
  assign out_mode              = out_res_r.mode;

endmodule

`default_nettype wire
